### src/swms_pkg.sv
package swms_pkg;

    localparam int CFG_W      = 7;
    localparam int MEAN_W     = 24;
    localparam int DEV_W      = 24;
    localparam int FRAC_W     = 8;
    localparam int VAR_FRAC_W = 2 * FRAC_W;
    localparam int LEN_RESET  = 16;
    localparam int LEN_MIN    = 2;
    localparam int MEAN_MAX   = 2 ** (MEAN_W - 1) - 1;
    localparam int DEV_MAX    = 2 ** DEV_W - 1;

    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } t_op;

endpackage

### src/sliding_window_mean_stddev.sv
// Sliding-window mean and sample standard deviation.
// Input channel i_valid/o_ready/i_sample: one signed sample per transfer.
// Output channel o_valid/i_ready: one result per sample (window_full, mean in
// signed Q8 rounded half away from zero, sample deviation in unsigned Q8).
// Config channel i_cfg_valid/o_cfg_ready/i_cfg_data writes window_len (clamped
// to 2..WINDOW_MAX); any write restarts filling. o_cfg_ready is high only while
// idle, and a pending write holds o_ready low.
// While the window is still filling the result is all zero and the block goes
// from idle straight to S_DONE, which loads the output register and raises
// o_valid once the slot is free. Once full, the block walks the sample RAM one
// entry per cycle through a shared multiplier, then runs a bit-serial unit for
// the mean division, the variance division and the square root.
// o_ready is high only while idle, so no new sample is taken until the last
// result moves to the output register; the next one can be taken in the same
// cycle that o_valid rises.
// A finished result waits in the output register while i_ready is low; the
// block then takes the next sample but holds its result until the slot frees.
// Reset (i_rst_n, synchronous) sets window_len to min(16, WINDOW_MAX) and empties the window.
module sliding_window_mean_stddev import swms_pkg::*; #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_window_full,
    output logic signed [MEAN_W-1:0]      o_window_mean,
    output logic [DEV_W-1:0]              o_window_std_dev
);

    localparam int NW      = $clog2(WINDOW_MAX + 1);
    localparam int PW      = $clog2(WINDOW_MAX);
    localparam int CW      = NW + 1;
    localparam int SB      = SAMPLE_BITS;
    localparam int SW      = SB + NW;
    localparam int S2W     = 2 * SB - 1 + NW;
    localparam int PRW     = S2W + SW;
    localparam int NUMW    = 2 * SW;
    localparam int DSW     = 2 * NW;
    localparam int XW      = NUMW + VAR_FRAC_W;
    localparam int MW      = SW + FRAC_W + 2;
    localparam int RW      = XW / 2;
    localparam int CNTW    = $clog2(XW + 1);
    localparam int DXW     = (RW > DEV_W) ? RW : DEV_W;
    localparam int LEN_RST = (WINDOW_MAX < LEN_RESET) ? WINDOW_MAX : LEN_RESET;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_WALK = 7'b0000010,
        S_PROD = 7'b0000100,
        S_MDIV = 7'b0001000,
        S_VDIV = 7'b0010000,
        S_SQRT = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state             r_state;
    logic [NW-1:0]      r_len;
    logic [NW-1:0]      r_fill;
    logic [PW-1:0]      r_wp;
    logic [CW-1:0]      r_idx;
    logic               r_rv;
    logic               r_mv;
    logic [1:0]         r_step;
    logic [SW-1:0]      r_s1;
    logic [S2W-1:0]     r_s2;
    logic [PRW-1:0]     r_prod;
    logic [NUMW-1:0]    r_num;
    logic [DSW-1:0]     r_den;
    logic               r_res_full;
    logic [MEAN_W-1:0]  r_res_mean;
    logic [DEV_W-1:0]   r_res_dev;
    logic               r_out_valid;
    logic               r_out_full;
    logic [MEAN_W-1:0]  r_out_mean;
    logic [DEV_W-1:0]   r_out_dev;

    logic [NW-1:0]      n_len;
    logic [PW-1:0]      n_wp;
    logic [NW-1:0]      n_fill;

    logic               in_acc;
    logic               out_free;
    logic [PW-1:0]      wa;
    logic [CW-1:0]      wp_inc;
    logic               now_full;
    logic               rd_issue;
    logic               walk_end;
    logic [SB-1:0]      ram_q;
    logic [SW-1:0]      samp_x;
    logic [SB-1:0]      samp_abs;
    logic [SW-1:0]      mag;
    logic [NW-1:0]      len_m1;
    logic [S2W-1:0]     mul_a;
    logic [SW-1:0]      mul_b;
    logic [PRW-1:0]     mul_p;
    logic [MW-1:0]      mean_dvd;
    logic               it_start;
    t_op                it_op;
    logic [XW-1:0]      it_x;
    logic [DSW-1:0]     it_d;
    logic [CNTW-1:0]    it_cnt;
    logic               it_done;
    logic [XW-1:0]      it_q;
    logic [MEAN_W-1:0]  mean_sat;
    logic [DXW-1:0]     dev_ext;
    logic [DEV_W-1:0]   dev_sat;

    // config clamp
    always_comb begin
        if (i_cfg_data < CFG_W'(LEN_MIN)) begin
            n_len = NW'(LEN_MIN);
        end else if (32'(i_cfg_data) > WINDOW_MAX) begin
            n_len = NW'(WINDOW_MAX);
        end else begin
            n_len = NW'(i_cfg_data);
        end
    end

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign wa       = (CW'(r_wp) >= CW'(r_len)) ? '0 : r_wp;
    assign wp_inc   = CW'(wa) + CW'(1);
    assign n_wp     = (wp_inc == CW'(r_len)) ? '0 : wp_inc[PW-1:0];
    assign n_fill   = (r_fill < r_len) ? (r_fill + NW'(1)) : r_fill;
    assign now_full = (n_fill >= r_len);

    assign rd_issue = (r_state == S_WALK) && (r_idx != CW'(r_len));
    assign walk_end = (r_idx == CW'(r_len)) && !r_rv && !r_mv;

    swms_ram #(
        .WIDTH (SB),
        .DEPTH (WINDOW_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (wa),
        .i_wdata (i_sample),
        .i_raddr (r_idx[PW-1:0]),
        .o_rdata (ram_q)
    );

    assign samp_x   = {{NW{ram_q[SB-1]}}, ram_q};
    assign samp_abs = ram_q[SB-1] ? (~ram_q + SB'(1)) : ram_q;
    assign mag      = r_s1[SW-1] ? (~r_s1 + SW'(1)) : r_s1;
    assign len_m1   = r_len - NW'(1);

    // shared multiplier: squares during the walk, then N*S2, S1^2, N*(N-1)
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_WALK: begin
                mul_a = S2W'(samp_abs);
                mul_b = SW'(samp_abs);
            end
            S_PROD: begin
                case (r_step)
                    2'd0: begin
                        mul_a = r_s2;
                        mul_b = SW'(r_len);
                    end
                    2'd1: begin
                        mul_a = S2W'(mag);
                        mul_b = mag;
                    end
                    2'd2: begin
                        mul_a = S2W'(r_len);
                        mul_b = SW'(len_m1);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // (2*|S1|*256 + N) / (2N) rounds half away from zero
    assign mean_dvd = {1'b0, mag, {(FRAC_W + 1){1'b0}}} + MW'(r_len);

    always_comb begin
        it_op  = OP_DIV;
        it_x   = {mean_dvd, {(XW - MW){1'b0}}};
        it_d   = DSW'({r_len, 1'b0});
        it_cnt = CNTW'(MW);
        case (r_state)
            S_MDIV: begin
                it_x   = {r_num, {VAR_FRAC_W{1'b0}}};
                it_d   = r_den;
                it_cnt = CNTW'(XW);
            end
            S_VDIV: begin
                it_op  = OP_SQRT;
                it_x   = it_q;
                it_d   = r_den;
                it_cnt = CNTW'(RW);
            end
            default: begin
                it_op  = OP_DIV;
            end
        endcase
    end

    assign it_start = ((r_state == S_PROD) && (r_step == 2'd3))
                   || (((r_state == S_MDIV) || (r_state == S_VDIV)) && it_done);

    swms_iter #(
        .XW (XW),
        .DW (DSW)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (it_start),
        .i_op    (it_op),
        .i_x     (it_x),
        .i_d     (it_d),
        .i_cnt   (it_cnt),
        .o_done  (it_done),
        .o_q     (it_q)
    );

    always_comb begin
        if (!r_s1[SW-1]) begin
            mean_sat = (it_q > XW'(MEAN_MAX)) ? MEAN_W'(MEAN_MAX) : it_q[MEAN_W-1:0];
        end else if (it_q > XW'(MEAN_MAX + 1)) begin
            mean_sat = {1'b1, {(MEAN_W - 1){1'b0}}};
        end else begin
            mean_sat = ~it_q[MEAN_W-1:0] + MEAN_W'(1);
        end
    end

    assign dev_ext = DXW'(it_q[RW-1:0]);
    assign dev_sat = (dev_ext > DXW'(DEV_MAX)) ? '1 : dev_ext[DEV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= NW'(LEN_RST);
            r_fill      <= '0;
            r_wp        <= '0;
            r_idx       <= '0;
            r_step      <= '0;
            r_rv        <= 1'b0;
            r_mv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rv <= rd_issue;
            r_mv <= r_rv;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_len  <= n_len;
                        r_fill <= '0;
                        r_wp   <= '0;
                    end else if (in_acc) begin
                        r_wp   <= n_wp;
                        r_fill <= n_fill;
                        r_idx  <= '0;
                        r_step <= '0;
                        r_state <= now_full ? S_WALK : S_DONE;
                    end
                end
                S_WALK: begin
                    if (rd_issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (walk_end) begin
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_state <= S_MDIV;
                    end
                end
                S_MDIV: begin
                    if (it_done) begin
                        r_state <= S_VDIV;
                    end
                end
                S_VDIV: begin
                    if (it_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (it_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if ((r_state == S_IDLE) && in_acc) begin
            r_s1       <= '0;
            r_s2       <= '0;
            r_res_full <= 1'b0;
            r_res_mean <= '0;
            r_res_dev  <= '0;
        end
        if (r_rv) begin
            r_s1 <= r_s1 + samp_x;
        end
        if (r_mv) begin
            r_s2 <= r_s2 + S2W'(r_prod);
        end
        if (r_state == S_PROD) begin
            case (r_step)
                2'd1: r_num <= NUMW'(r_prod);
                2'd2: r_num <= (r_num >= NUMW'(r_prod)) ? (r_num - NUMW'(r_prod)) : '0;
                2'd3: r_den <= DSW'(r_prod);
                default: begin
                end
            endcase
        end
        if ((r_state == S_MDIV) && it_done) begin
            r_res_mean <= mean_sat;
        end
        if ((r_state == S_SQRT) && it_done) begin
            r_res_dev  <= dev_sat;
            r_res_full <= 1'b1;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_full <= r_res_full;
            r_out_mean <= r_res_mean;
            r_out_dev  <= r_res_dev;
        end
    end

    assign o_cfg_ready      = (r_state == S_IDLE);
    assign o_ready          = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_valid          = r_out_valid;
    assign o_window_full    = r_out_full;
    assign o_window_mean    = r_out_mean;
    assign o_window_std_dev = r_out_dev;

endmodule

### src/swms_ram.sv
module swms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/swms_iter.sv
// Restoring shift-subtract unit: one quotient bit (divide) or one root bit
// (square root) per cycle. The operand is consumed MSB first from i_x, so a
// short dividend is left-aligned and run with a smaller i_cnt.
module swms_iter import swms_pkg::*; #(
    parameter int XW = 62,
    parameter int DW = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  t_op                    i_op,
    input  logic [XW-1:0]          i_x,
    input  logic [DW-1:0]          i_d,
    input  logic [$clog2(XW+1)-1:0] i_cnt,
    output logic                   o_done,
    output logic [XW-1:0]          o_q
);

    localparam int RW   = XW / 2;
    localparam int UW   = RW + 3;
    localparam int CNTW = $clog2(XW + 1);

    logic            r_busy;
    logic            r_done;
    t_op             r_op;
    logic [XW-1:0]   r_x;
    logic [DW-1:0]   r_d;
    logic [XW-1:0]   r_q;
    logic [UW-1:0]   r_rem;
    logic [CNTW-1:0] r_cnt;

    logic [UW-1:0]   pre;
    logic [UW-1:0]   sub;
    logic [UW-1:0]   diff;
    logic            ge;

    always_comb begin
        if (r_op == OP_SQRT) begin
            pre = {r_rem[UW-3:0], r_x[XW-1 -: 2]};
            sub = {r_q[UW-3:0], 2'b01};
        end else begin
            pre = {r_rem[UW-2:0], r_x[XW-1]};
            sub = UW'(r_d);
        end
        ge   = (pre >= sub);
        diff = pre - sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNTW'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_x   <= i_x;
            r_d   <= i_d;
            r_q   <= '0;
            r_rem <= '0;
            r_cnt <= i_cnt;
        end else if (r_busy) begin
            r_rem <= ge ? diff : pre;
            r_q   <= {r_q[XW-2:0], ge};
            r_x   <= (r_op == OP_SQRT) ? (r_x << 2) : (r_x << 1);
            r_cnt <= r_cnt - CNTW'(1);
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule
